/* hdl/float_to_engineering_display_macros.svh */
// ----------------------------------------------------------------------------
// float_to_engineering_display assertion macros
// Concurrent checks on the display formatter; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef FLOAT_TO_ENGINEERING_DISPLAY_MACROS_SVH
`define FLOAT_TO_ENGINEERING_DISPLAY_MACROS_SVH

`ifndef SYNTHESIS
// check a condition at every clock edge out of reset
`define FTED_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("fted check failed");
// check that a trigger implies a result in the next cycle
`define FTED_ASSERT_NEXT(label, trig, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (post)) \
		else $error("fted check failed");
`else
`define FTED_ASSERT_ALWAYS(label, cond)
`define FTED_ASSERT_NEXT(label, trig, post)
`endif

`endif

/* hdl/fted_pkg.sv */
// ----------------------------------------------------------------------------
// fted_pkg
// Types, character and prefix codes, and scale tables for the formatter.
// ----------------------------------------------------------------------------
package fted_pkg;

	// character codes
	localparam logic [4:0] CH_DOT  = 5'd10;
	localparam logic [4:0] CH_B    = 5'd11;
	localparam logic [4:0] CH_I    = 5'd12;
	localparam logic [4:0] CH_G    = 5'd13;
	localparam logic [4:0] CH_T    = 5'd14;
	localparam logic [4:0] CH_N    = 5'd15;
	localparam logic [4:0] CH_Y    = 5'd16;
	localparam logic [4:0] CH_BANG = 5'd17;
	localparam logic [4:0] CH_ZERO = 5'd0;

	// prefix codes
	localparam logic [2:0] PFX_NONE  = 3'd0;
	localparam logic [2:0] PFX_PICO  = 3'd1;
	localparam logic [2:0] PFX_NANO  = 3'd2;
	localparam logic [2:0] PFX_MICRO = 3'd3;
	localparam logic [2:0] PFX_MILLI = 3'd4;
	localparam logic [2:0] PFX_KILO  = 3'd5;
	localparam logic [2:0] PFX_MEGA  = 3'd6;
	localparam logic [2:0] PFX_GIGA  = 3'd7;

	// what the word shows
	localparam logic [1:0] MSG_NUM  = 2'd0;
	localparam logic [1:0] MSG_ZERO = 2'd1;
	localparam logic [1:0] MSG_BIG  = 2'd2;
	localparam logic [1:0] MSG_TINY = 2'd3;

	// fixed shift of the reciprocal constants
	localparam logic [6:0] RECIP_SHIFT = 7'd54;

	localparam int A_W  = 33;
	localparam int C_W  = 52;
	localparam int CH_W = 26;
	localparam int W_W  = 20;

	// operands of one exact scaling: floor(a * c / 2^sh)
	typedef struct packed {
		logic [A_W-1:0] a;
		logic [C_W-1:0] c;
		logic [6:0]     sh;
	} scale_op_t;

	// status that travels beside the scaling pipeline
	typedef struct packed {
		logic [1:0]        msg;
		logic              sign;
		logic signed [5:0] p0;
	} side_t;

	// prefix choice for one decade
	typedef struct packed {
		logic       big;
		logic       tiny;
		logic [1:0] lead;
		logic [2:0] prefix;
	} dec_t;

	// 5^k for k >= 0, else ceil(2^54 / 5^-k)
	function automatic logic [C_W-1:0] scale_const(input logic signed [7:0] k);
		logic [C_W-1:0] c;
		begin
			case (k)
				8'sd0:  c = 52'd1;
				8'sd1:  c = 52'd5;
				8'sd2:  c = 52'd25;
				8'sd3:  c = 52'd125;
				8'sd4:  c = 52'd625;
				8'sd5:  c = 52'd3125;
				8'sd6:  c = 52'd15625;
				8'sd7:  c = 52'd78125;
				8'sd8:  c = 52'd390625;
				8'sd9:  c = 52'd1953125;
				8'sd10: c = 52'd9765625;
				8'sd11: c = 52'd48828125;
				8'sd12: c = 52'd244140625;
				8'sd13: c = 52'd1220703125;
				8'sd14: c = 52'd6103515625;
				8'sd15: c = 52'd30517578125;
				8'sd16: c = 52'd152587890625;
				-8'sd1: c = 52'd3602879701896397;
				-8'sd2: c = 52'd720575940379280;
				-8'sd3: c = 52'd144115188075856;
				-8'sd4: c = 52'd28823037615172;
				-8'sd5: c = 52'd5764607523035;
				-8'sd6: c = 52'd1152921504607;
				-8'sd7: c = 52'd230584300922;
				-8'sd8: c = 52'd46116860185;
				-8'sd9: c = 52'd9223372037;
				default: c = 52'd0;
			endcase
			return c;
		end
	endfunction

	// operands giving floor(2 * m * 2^(e2-23) * 10^(3-pc))
	function automatic scale_op_t build_op(input logic [23:0] m,
		input logic signed [7:0] e2, input logic signed [7:0] pc);
		logic signed [7:0] k;
		logic signed [7:0] t;
		scale_op_t op;
		begin
			k = 8'sd3 - pc;
			t = e2 - 8'sd22 + k;
			op.c = scale_const(k);
			if (k >= 8'sd0) begin
				op.a  = A_W'(m);
				op.sh = 7'(-t);
			end else begin
				op.a  = (t > 8'sd0) ? (A_W'(m) << t[3:0]) : A_W'(m);
				op.sh = (t < 8'sd0) ? 7'(8'sd54 - t) : RECIP_SHIFT;
			end
			return op;
		end
	endfunction

	// split a decade into prefix and number of leading digits
	function automatic dec_t decade_split(input logic signed [5:0] p);
		logic signed [5:0] base;
		dec_t d;
		begin
			d.big  = 1'b0;
			d.tiny = 1'b0;
			base   = 6'sd0;
			d.prefix = PFX_NONE;
			if (p >= 6'sd12) begin
				d.big = 1'b1;
			end else if (p >= 6'sd9) begin
				base = 6'sd9;  d.prefix = PFX_GIGA;
			end else if (p >= 6'sd6) begin
				base = 6'sd6;  d.prefix = PFX_MEGA;
			end else if (p >= 6'sd3) begin
				base = 6'sd3;  d.prefix = PFX_KILO;
			end else if (p >= 6'sd0) begin
				base = 6'sd0;  d.prefix = PFX_NONE;
			end else if (p >= -6'sd3) begin
				base = -6'sd3; d.prefix = PFX_MILLI;
			end else if (p >= -6'sd6) begin
				base = -6'sd6; d.prefix = PFX_MICRO;
			end else if (p >= -6'sd9) begin
				base = -6'sd9; d.prefix = PFX_NANO;
			end else if (p >= -6'sd12) begin
				base = -6'sd12; d.prefix = PFX_PICO;
			end else begin
				d.tiny = 1'b1;
			end
			d.lead = 2'(p - base + 6'sd1);
			return d;
		end
	endfunction

endpackage

/* hdl/fted_scale.sv */
// ----------------------------------------------------------------------------
// fted_scale
// Three-stage exact scaler: split multiply, partial-product add, shift.
// ----------------------------------------------------------------------------
module fted_scale (
	input  logic                  clk,
	input  logic                  adv,
	input  fted_pkg::scale_op_t   op,
	output logic [fted_pkg::W_W-1:0] w
);
	import fted_pkg::*;

	localparam int P_W = A_W + CH_W;
	localparam int S_W = A_W + C_W;

	logic [P_W-1:0] prod_lo_s2;
	logic [P_W-1:0] prod_hi_s2;
	logic [6:0]     sh_s2;
	logic [S_W-1:0] sum_s3;
	logic [6:0]     sh_s3;
	logic [W_W-1:0] w_s4;

	// multiply against both halves of the constant
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_lo_s2 <= op.a * op.c[CH_W-1:0];
			prod_hi_s2 <= op.a * op.c[C_W-1:CH_W];
			sh_s2      <= op.sh;
		end
	end

	// add the partial products
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= S_W'(prod_lo_s2) + {prod_hi_s2, {CH_W{1'b0}}};
			sh_s3  <= sh_s2;
		end
	end

	// drop the fraction bits
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s4 <= W_W'(sum_s3 >> sh_s3);
		end
	end

	assign w = w_s4;

endmodule

/* hdl/float_to_engineering_display.sv */
// Throughput: one word per cycle; a stalled output holds the whole pipeline.
// The depth is set by the exact scaling: a split 33x26 multiply, a wide
// partial-product add and a wide shift, each in its own stage.
// Reset clears every valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
// float_to_engineering_display
// Formats a binary32 value as sign, five characters and an SI prefix.
// ----------------------------------------------------------------------------
`include "float_to_engineering_display_macros.svh"

module float_to_engineering_display (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        value_valid,
	output logic        value_stall,
	input  logic [31:0] value_bits,
	output logic        disp_valid,
	input  logic        disp_stall,
	output logic        sign_code,
	output logic [4:0]  pos0_code,
	output logic [4:0]  pos1_code,
	output logic [4:0]  pos2_code,
	output logic [4:0]  pos3_code,
	output logic [4:0]  pos4_code,
	output logic [2:0]  prefix_code
);
	import fted_pkg::*;

	logic adv;

	// stage 1: decode
	logic [7:0]         ef;
	logic [22:0]        frac;
	logic signed [8:0]  e2_raw;
	logic signed [7:0]  e2c;
	logic signed [17:0] est;
	logic signed [5:0]  p0;
	logic [1:0]         msg_in;
	logic               sign_in;
	logic [23:0]        mant;

	logic      valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic      valid_s6, valid_s7, valid_s8;
	side_t     side_s1, side_s2, side_s3, side_s4;
	scale_op_t op_up_s1, op_dn_s1;
	logic [W_W-1:0] w_up, w_dn;

	// stage 5
	logic              up_ok;
	logic [W_W-1:0]    w_sel;
	logic signed [5:0] p_sel;
	logic [W_W:0]      n_wide;
	logic [1:0]        msg_s5;
	logic              sign_s5;
	logic signed [5:0] p_s5;
	logic [13:0]       n_s5;

	// stage 6
	dec_t        dec;
	logic [27:0] th_prod;
	logic [3:0]  d0_c;
	logic [1:0]  msg_s6;
	logic        sign_s6;
	logic [1:0]  lead_s6;
	logic [2:0]  prefix_s6;
	logic [3:0]  d0_s6;
	logic [9:0]  r1_s6;

	// stage 7
	logic [22:0] hu_prod;
	logic [3:0]  d1_c;
	logic [1:0]  msg_s7;
	logic        sign_s7;
	logic [1:0]  lead_s7;
	logic [2:0]  prefix_s7;
	logic [3:0]  d0_s7, d1_s7;
	logic [6:0]  r2_s7;

	// stage 8
	logic [14:0] te_prod;
	logic [3:0]  d2_c, d3_c;
	logic [4:0]  c0, c1, c2, c3, c4;
	logic [2:0]  pfx_c;
	logic        sign_s8;
	logic [4:0]  pos0_s8, pos1_s8, pos2_s8, pos3_s8, pos4_s8;
	logic [2:0]  prefix_s8;

	// advance unless a finished word is held at the output
	assign adv         = !(valid_s8 && disp_stall);
	assign value_stall = !adv;

	// classify the input and estimate its decade
	always_comb begin
		ef     = value_bits[30:23];
		frac   = value_bits[22:0];
		mant   = {1'b1, frac};
		e2_raw = $signed({1'b0, ef}) - 9'sd127;
		if (value_bits[30:0] == 31'd0) begin
			msg_in = MSG_ZERO;
		end else if (ef == 8'hFF) begin
			msg_in = MSG_BIG;
		end else if (ef == 8'd0 || e2_raw <= -9'sd44) begin
			msg_in = MSG_TINY;
		end else if (e2_raw >= 9'sd40) begin
			msg_in = MSG_BIG;
		end else begin
			msg_in = MSG_NUM;
		end
		sign_in = value_bits[31] && (value_bits[30:0] != 31'd0)
			&& !(ef == 8'hFF && frac != 23'd0);
		e2c = (msg_in == MSG_NUM) ? 8'(e2_raw) : 8'sd0;
		est = 18'(e2c) * 18'sd1233;
		p0  = 6'(est >>> 12);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.msg  <= msg_in;
			side_s1.sign <= sign_in;
			side_s1.p0   <= p0;
			op_up_s1     <= build_op(mant, e2c, 8'(p0) + 8'sd1);
			op_dn_s1     <= build_op(mant, e2c, 8'(p0));
		end
	end

	// exact scaling for both decade candidates
	fted_scale u_scale_up (
		.clk (clk),
		.adv (adv),
		.op  (op_up_s1),
		.w   (w_up)
	);

	fted_scale u_scale_dn (
		.clk (clk),
		.adv (adv),
		.op  (op_dn_s1),
		.w   (w_dn)
	);

	// carry status beside the scaler
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_s1;
			side_s3 <= side_s2;
			side_s4 <= side_s3;
		end
	end

	// pick the decade, round half up, fix a rounding carry
	always_comb begin
		up_ok  = (w_up >= W_W'(2000));
		w_sel  = up_ok ? w_up : w_dn;
		p_sel  = up_ok ? (side_s4.p0 + 6'sd1) : side_s4.p0;
		n_wide = ({1'b0, w_sel} + (W_W+1)'(1)) >> 1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			msg_s5  <= side_s4.msg;
			sign_s5 <= side_s4.sign;
			if (n_wide >= (W_W+1)'(10000)) begin
				p_s5 <= p_sel + 6'sd1;
				n_s5 <= 14'd1000;
			end else begin
				p_s5 <= p_sel;
				n_s5 <= 14'(n_wide);
			end
		end
	end

	// choose prefix and peel the thousands digit
	always_comb begin
		dec     = decade_split(p_s5);
		th_prod = 28'(n_s5) * 28'd8389;
		d0_c    = th_prod[26:23];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (msg_s5 == MSG_NUM && dec.big) begin
				msg_s6 <= MSG_BIG;
			end else if (msg_s5 == MSG_NUM && dec.tiny) begin
				msg_s6 <= MSG_TINY;
			end else begin
				msg_s6 <= msg_s5;
			end
			sign_s6   <= sign_s5;
			lead_s6   <= dec.lead;
			prefix_s6 <= dec.prefix;
			d0_s6     <= d0_c;
			r1_s6     <= 10'(n_s5 - 14'(d0_c) * 14'd1000);
		end
	end

	// peel the hundreds digit
	always_comb begin
		hu_prod = 23'(r1_s6) * 23'd5243;
		d1_c    = hu_prod[22:19];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			msg_s7    <= msg_s6;
			sign_s7   <= sign_s6;
			lead_s7   <= lead_s6;
			prefix_s7 <= prefix_s6;
			d0_s7     <= d0_s6;
			d1_s7     <= d1_c;
			r2_s7     <= 7'(r1_s6 - 10'(d1_c) * 10'd100);
		end
	end

	// last two digits and character placement
	always_comb begin
		te_prod = 15'(r2_s7) * 15'd205;
		d2_c    = te_prod[14:11];
		d3_c    = 4'(r2_s7 - 7'(d2_c) * 7'd10);
		pfx_c   = PFX_NONE;
		c0 = CH_ZERO; c1 = CH_DOT; c2 = CH_ZERO; c3 = CH_ZERO; c4 = CH_ZERO;
		case (msg_s7)
			MSG_NUM: begin
				pfx_c = prefix_s7;
				case (lead_s7)
					2'd1: begin
						c0 = 5'(d0_s7); c1 = CH_DOT;     c2 = 5'(d1_s7);
						c3 = 5'(d2_c);  c4 = 5'(d3_c);
					end
					2'd2: begin
						c0 = 5'(d0_s7); c1 = 5'(d1_s7);  c2 = CH_DOT;
						c3 = 5'(d2_c);  c4 = 5'(d3_c);
					end
					default: begin
						c0 = 5'(d0_s7); c1 = 5'(d1_s7);  c2 = 5'(d2_c);
						c3 = CH_DOT;    c4 = 5'(d3_c);
					end
				endcase
			end
			MSG_BIG: begin
				c0 = CH_B; c1 = CH_I; c2 = CH_G; c3 = CH_BANG; c4 = CH_BANG;
			end
			MSG_TINY: begin
				c0 = CH_T; c1 = CH_I; c2 = CH_N; c3 = CH_Y; c4 = CH_BANG;
			end
			default: begin
				c0 = CH_ZERO; c1 = CH_DOT; c2 = CH_ZERO; c3 = CH_ZERO; c4 = CH_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sign_s8   <= sign_s7;
			pos0_s8   <= c0;
			pos1_s8   <= c1;
			pos2_s8   <= c2;
			pos3_s8   <= c3;
			pos4_s8   <= c4;
			prefix_s8 <= pfx_c;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
			valid_s8 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= value_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
			valid_s8 <= valid_s7;
		end
	end

	assign disp_valid  = valid_s8;
	assign sign_code   = sign_s8;
	assign pos0_code   = pos0_s8;
	assign pos1_code   = pos1_s8;
	assign pos2_code   = pos2_s8;
	assign pos3_code   = pos3_s8;
	assign pos4_code   = pos4_s8;
	assign prefix_code = prefix_s8;

	// a prefix only ever comes with a number
	`FTED_ASSERT_ALWAYS(a_prefix_digits, !(valid_s8 && prefix_s8 != PFX_NONE) || (pos0_s8 <= CH_DOT && pos4_s8 <= CH_DOT))
	// the dot never opens or closes the field
	`FTED_ASSERT_ALWAYS(a_dot_place, !valid_s8 || (pos0_s8 != CH_DOT && pos4_s8 != CH_DOT))
	// a held output freezes the pipeline behind it
	`FTED_ASSERT_NEXT(a_hold_pipe, valid_s8 && disp_stall, $stable(valid_s4) && $stable(valid_s7))

endmodule

/* sim/float_to_engineering_display_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// float_to_engineering_display_tb
// Drives binary32 value words into the display formatter and checks every
// display word against a predictor that rounds the float exactly to four
// significant digits and picks the SI prefix. Both sides idle at random.
// ----------------------------------------------------------------------------
module float_to_engineering_display_tb;
	import fted_pkg::*;

	typedef struct packed {
		logic       sign;
		logic [4:0] c0;
		logic [4:0] c1;
		logic [4:0] c2;
		logic [4:0] c3;
		logic [4:0] c4;
		logic [2:0] prefix;
	} disp_word_t;

	logic        clk;
	logic        arst_n;
	logic        value_valid;
	logic        value_stall;
	logic [31:0] value_bits;
	logic        disp_valid;
	logic        disp_stall;
	logic        sign_code;
	logic [4:0]  pos0_code;
	logic [4:0]  pos1_code;
	logic [4:0]  pos2_code;
	logic [4:0]  pos3_code;
	logic [4:0]  pos4_code;
	logic [2:0]  prefix_code;

	logic [31:0] pending_values[$];
	disp_word_t  expected_words[$];
	int          send_wait;
	int          recv_wait;
	int          cycle_count;
	int          fail_count;
	bit          stimulus_done;

	float_to_engineering_display i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value_bits  (value_bits),
		.disp_valid  (disp_valid),
		.disp_stall  (disp_stall),
		.sign_code   (sign_code),
		.pos0_code   (pos0_code),
		.pos1_code   (pos1_code),
		.pos2_code   (pos2_code),
		.pos3_code   (pos3_code),
		.pos4_code   (pos4_code),
		.prefix_code (prefix_code)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// round or truncate m * 2^e * 10^k to an integer, saturating
	function automatic longint unsigned scale_decimal(longint unsigned m, int e, int k,
		bit round_up);
		longint unsigned num, den, q, r;
		int s;
		num = m;
		den = 1;
		s = e + k;
		if (k >= 0) begin
			for (int i = 0; i < k && i < 20; i++) num *= 5;
		end else begin
			for (int i = 0; i < -k && i < 20; i++) den *= 5;
		end
		if (s >= 0) begin
			if (s > 62 || num > (64'hFFFF_FFFF_FFFF_FFFF >> s))
				return 64'hFFFF_FFFF_FFFF_FFFF;
			num = num << s;
		end else begin
			if (-s > 62 || den > (64'hFFFF_FFFF_FFFF_FFFF >> (-s)))
				return 0;
			den = den << (-s);
		end
		q = num / den;
		r = num % den;
		if (round_up && r >= den - r) q++;
		return q;
	endfunction

	// work out the display word for one value
	function automatic disp_word_t format_value(logic [31:0] bits);
		disp_word_t w;
		logic [7:0]  ef;
		logic [22:0] frac;
		int e2, t, p0, p, pre, lead, j;
		longint unsigned m, n;
		logic [4:0] dig[4];
		logic [4:0] pos[5];
		ef = bits[30:23];
		frac = bits[22:0];
		w = '0;
		if (bits[30:0] == 0) begin
			w.c1 = CH_DOT;
			return w;
		end
		if (ef == 8'hFF) begin
			w.sign = (frac == 0) && bits[31];
			{w.c0, w.c1, w.c2, w.c3, w.c4} = {CH_B, CH_I, CH_G, CH_BANG, CH_BANG};
			return w;
		end
		w.sign = bits[31];
		e2 = int'(ef) - 127;
		if (ef == 0 || e2 <= -44) begin
			{w.c0, w.c1, w.c2, w.c3, w.c4} = {CH_T, CH_I, CH_N, CH_Y, CH_BANG};
			return w;
		end
		if (e2 >= 40) begin
			{w.c0, w.c1, w.c2, w.c3, w.c4} = {CH_B, CH_I, CH_G, CH_BANG, CH_BANG};
			return w;
		end
		m = {40'd0, 1'b1, frac};
		// estimate the decade, then correct it
		t = e2 * 1233;
		p0 = (t >= 0) ? (t / 4096) : -((-t + 4095) / 4096);
		p = p0 + 1;
		if (scale_decimal(m, e2 - 23, 3 - p, 1'b0) < 1000) p = p0;
		n = scale_decimal(m, e2 - 23, 3 - p, 1'b1);
		if (n >= 10000) begin
			p++;
			n = 1000;
		end
		pre = (p >= 0) ? (p / 3) * 3 : -(((-p) + 2) / 3) * 3;
		if (pre > 9) begin
			{w.c0, w.c1, w.c2, w.c3, w.c4} = {CH_B, CH_I, CH_G, CH_BANG, CH_BANG};
			return w;
		end
		if (pre < -12) begin
			{w.c0, w.c1, w.c2, w.c3, w.c4} = {CH_T, CH_I, CH_N, CH_Y, CH_BANG};
			return w;
		end
		lead = p - pre + 1;
		for (int i = 3; i >= 0; i--) begin
			dig[i] = 5'(n % 10);
			n = n / 10;
		end
		j = 0;
		for (int i = 0; i < 5; i++) begin
			if (i == lead) pos[i] = CH_DOT;
			else begin
				pos[i] = (j < 4) ? dig[j] : CH_ZERO;
				j++;
			end
		end
		{w.c0, w.c1, w.c2, w.c3, w.c4} = {pos[0], pos[1], pos[2], pos[3], pos[4]};
		case (pre)
			-12: w.prefix = PFX_PICO;
			-9: w.prefix = PFX_NANO;
			-6: w.prefix = PFX_MICRO;
			-3: w.prefix = PFX_MILLI;
			3: w.prefix = PFX_KILO;
			6: w.prefix = PFX_MEGA;
			9: w.prefix = PFX_GIGA;
			default: w.prefix = PFX_NONE;
		endcase
		return w;
	endfunction

	// fill the value queue: directed corners, then random values
	initial begin
		logic [31:0] v;
		logic [7:0]  ex;
		pending_values.push_back(32'h0000_0000);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'h7F80_0000);
		pending_values.push_back(32'hFF80_0000);
		pending_values.push_back(32'h7FC0_0001);
		pending_values.push_back(32'hFFFF_FFFF);
		pending_values.push_back(32'h0000_0001);
		pending_values.push_back(32'h807F_FFFF);
		pending_values.push_back(32'h7F7F_FFFF);
		pending_values.push_back(32'h3F80_0000);  // 1.0
		pending_values.push_back(32'h411F_FF2E);  // 9.9998, carries to 10.00
		pending_values.push_back(32'h4479_FFF0);  // 999.99, carries to kilo
		pending_values.push_back(32'h2B8C_BCCC);  // near 1e-12
		pending_values.push_back(32'h2B8C_0000);  // just below 1e-12
		pending_values.push_back(32'h5368_D4A5);  // near 1e12
		pending_values.push_back(32'h4E6E_6B28);  // 1e9
		pending_values.push_back(32'hBF00_0000);
		pending_values.push_back(32'h3DCC_CCCD);  // 0.1
		pending_values.push_back(32'h4640_E400);  // 12345
		pending_values.push_back(32'h1000_0000);
		pending_values.push_back(32'h6000_0000);
		for (int i = 0; i < 1400; i++) begin
			v = $urandom;
			// mostly exponents inside the display range
			if ($urandom_range(0, 9) < 8) begin
				ex = 8'($urandom_range(84, 167));
				v[30:23] = ex;
			end
			pending_values.push_back(v);
		end
		stimulus_done = 1'b1;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// drive value words, with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_valid <= 1'b0;
			value_bits  <= '0;
			send_wait   <= $urandom_range(0, 17);
		end else begin
			if (value_valid && !value_stall) begin
				expected_words.push_back(format_value(value_bits));
			end
			if (!value_valid || !value_stall) begin
				if (send_wait > 0 || pending_values.size() == 0) begin
					value_valid <= 1'b0;
					if (send_wait > 0) send_wait <= send_wait - 1;
				end else begin
					value_valid <= 1'b1;
					value_bits  <= pending_values.pop_front();
					send_wait   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
				end
			end
		end
	end

	// accept display words and compare; hold stall for the drawn wait after each word
	always @(posedge clk or negedge arst_n) begin
		disp_word_t exp_w;
		int         wait_draw;
		if (!arst_n) begin
			disp_stall <= 1'b0;
			recv_wait  <= 0;
		end else begin
			if (disp_valid && !disp_stall) begin
				if (expected_words.size() == 0) begin
					$error("display word with nothing expected");
					fail_count++;
				end else begin
					exp_w = expected_words.pop_front();
					if (sign_code !== exp_w.sign) begin
						$error("sign_code exp %0d got %0d", exp_w.sign, sign_code);
						fail_count++;
					end
					if (pos0_code !== exp_w.c0) begin
						$error("pos0_code exp %0d got %0d", exp_w.c0, pos0_code);
						fail_count++;
					end
					if (pos1_code !== exp_w.c1) begin
						$error("pos1_code exp %0d got %0d", exp_w.c1, pos1_code);
						fail_count++;
					end
					if (pos2_code !== exp_w.c2) begin
						$error("pos2_code exp %0d got %0d", exp_w.c2, pos2_code);
						fail_count++;
					end
					if (pos3_code !== exp_w.c3) begin
						$error("pos3_code exp %0d got %0d", exp_w.c3, pos3_code);
						fail_count++;
					end
					if (pos4_code !== exp_w.c4) begin
						$error("pos4_code exp %0d got %0d", exp_w.c4, pos4_code);
						fail_count++;
					end
					if (prefix_code !== exp_w.prefix) begin
						$error("prefix_code exp %0d got %0d", exp_w.prefix, prefix_code);
						fail_count++;
					end
				end
				wait_draw = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17);
				recv_wait  <= wait_draw;
				disp_stall <= (wait_draw > 0);
			end else if (recv_wait > 0) begin
				disp_stall <= (recv_wait > 1);
				recv_wait  <= recv_wait - 1;
			end else begin
				disp_stall <= 1'b0;
			end
		end
	end

	// wait for drain, then report
	initial begin
		fail_count = 0;
		cycle_count = 0;
		@(posedge arst_n);
		while (!(stimulus_done && pending_values.size() == 0 && !value_valid &&
			expected_words.size() == 0) && cycle_count < 400000) begin
			@(posedge clk);
			cycle_count++;
		end
		if (cycle_count >= 400000) begin
			$display("float_to_engineering_display verification failed");
			$finish;
		end else begin
			repeat (30) @(posedge clk);
			if (fail_count == 0 && expected_words.size() == 0)
				$display("float_to_engineering_display verification clean");
			else
				$display("float_to_engineering_display verification failed");
			$finish;
		end
	end
endmodule
